FILE: sv/raised_cosine_bump_adder_assert.svh
// Assertion helpers for the bump adder.
`ifndef RAISED_COSINE_BUMP_ADDER_ASSERT_SVH
`define RAISED_COSINE_BUMP_ADDER_ASSERT_SVH

// same-cycle implication
`define RCB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bump adder check failed");

// next-cycle implication
`define RCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bump adder check failed");

`endif

FILE: sv/rcb_pkg.sv
`default_nettype none
package rcb_pkg;

   localparam int COORD_W    = 10;
   localparam int HGT_W      = 32;
   localparam int RAD_W      = 10;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int D2_W       = SQ_W + 2;
   localparam int FRAC_W     = 8;
   localparam int RADICAND_W = D2_W + 2 * FRAC_W;
   localparam int ROOT_W     = RADICAND_W / 2;
   localparam int REM_W      = ROOT_W + 3;
   localparam int DIVS_W     = RAD_W + 9;
   localparam int WT_W       = 17;
   localparam int PROD_W     = HGT_W + WT_W + 1;
   localparam int CSR_W      = 3;

   localparam logic [CSR_W-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CSR_W-1:0] CSR_CENTER_Z = 3'd1;
   localparam logic [CSR_W-1:0] CSR_RADIUS   = 3'd2;
   localparam logic [CSR_W-1:0] CSR_HEIGHT   = 3'd3;

   localparam logic [63:0]        PI_Q30  = 64'd3373259426;
   localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

   typedef struct packed {
      logic [COORD_W-1:0]      pixel_x;
      logic [COORD_W-1:0]      pixel_z;
      logic signed [HGT_W-1:0] height_in;
   } req_type;

   typedef struct packed {
      logic signed [HGT_W-1:0] height_out;
      logic                    inside_circle;
      logic                    saturated;
   } rsp_type;

   // what travels alongside the arithmetic
   typedef struct packed {
      logic signed [HGT_W-1:0] height;
      logic                    in_circle;
   } carry_type;

   // cos in Q30 of an angle in Q30 within [0, pi/2], truncating Taylor steps
   function automatic logic signed [63:0] cos_q30(input logic [63:0] theta);
      logic [63:0]        t2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      t2   = (theta * theta) >> 30;
      term = 64'(ONE_Q30);
      acc  = ONE_Q30;
      for (int n = 1; n <= 12; n++) begin
         term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

FILE: sv/raised_cosine_bump_adder.sv
// Raised-cosine bump adder.
// Input channel req_*: one height-map pixel per item (pixel_x, pixel_z,
// height_in in signed Q16.16). Result channel rsp_*: one item per pixel,
// in order: height_out (saturated), inside_circle, saturated.
// Configuration csr_*: write centre, radius and amplitude while no item
// is in flight; writes take effect at the clock edge, no read-back.
// Throughput: one item per cycle while the receiver does not stall a result.
// The pipeline depth is set by the digit-by-digit square root (one result
// bit per stage, 19 stages) and the restoring divider that scales the
// distance to a table index (one quotient bit per stage).
// Reset (synchronous, active high) empties the pipeline and sets the
// centre to 0, radius to 1 and amplitude to 0.
// While a valid result is stalled, the whole pipeline holds and req_stall
// rises; no item is lost or repeated, and the result stays on rsp_data.
`default_nettype none
module raised_cosine_bump_adder #(
   parameter int MAP_SIDE        = 1024,
   parameter int COS_TABLE_DEPTH = 256
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  rcb_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output rcb_pkg::rsp_type                   rsp_data,
   input  wire                                csr_we,
   input  wire  [rcb_pkg::CSR_W-1:0]          csr_index,
   input  wire  [rcb_pkg::HGT_W-1:0]          csr_wdata
);

`include "raised_cosine_bump_adder_assert.svh"

   localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1);
   localparam int NUM_W = rcb_pkg::ROOT_W + 2 + $clog2(COS_TABLE_DEPTH);
   localparam int SQ_N  = rcb_pkg::ROOT_W;

   // weight table, Q1.16 of (1 + cos(pi*k/depth)) / 2
   typedef logic [rcb_pkg::WT_W-1:0] wtab_type [COS_TABLE_DEPTH+1];

   function automatic logic [rcb_pkg::WT_W-1:0] weight_of(input int unsigned k);
      logic signed [63:0] c;
      logic signed [63:0] w;
      if (2 * k <= COS_TABLE_DEPTH) begin
         c = rcb_pkg::cos_q30(rcb_pkg::PI_Q30 * 64'(k) / COS_TABLE_DEPTH);
      end else begin
         c = -rcb_pkg::cos_q30(rcb_pkg::PI_Q30 * 64'(COS_TABLE_DEPTH - k)
                               / COS_TABLE_DEPTH);
      end
      w = (rcb_pkg::ONE_Q30 + c) / 2;
      if (w < 0) begin
         w = 0;
      end
      return rcb_pkg::WT_W'((w + 64'sd8192) >>> 14);
   endfunction

   function automatic wtab_type build_wtab();
      wtab_type t;
      for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
         t[k] = weight_of(k);
      end
      return t;
   endfunction

   localparam wtab_type WTAB = build_wtab();

   // configuration
   logic [rcb_pkg::COORD_W-1:0]      center_x_ff;
   logic [rcb_pkg::COORD_W-1:0]      center_z_ff;
   logic [rcb_pkg::RAD_W-1:0]        radius_ff;
   logic signed [rcb_pkg::HGT_W-1:0] bump_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= '0;
         center_z_ff    <= '0;
         radius_ff      <= rcb_pkg::RAD_W'(1);
         bump_height_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rcb_pkg::CSR_CENTER_X: center_x_ff    <= csr_wdata[rcb_pkg::COORD_W-1:0];
            rcb_pkg::CSR_CENTER_Z: center_z_ff    <= csr_wdata[rcb_pkg::COORD_W-1:0];
            rcb_pkg::CSR_RADIUS:   radius_ff      <= csr_wdata[rcb_pkg::RAD_W-1:0];
            rcb_pkg::CSR_HEIGHT:   bump_height_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // global advance: the pipeline moves unless the output is held
   logic adv;
   logic rsp_valid_ff;
   rcb_pkg::rsp_type rsp_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // stage 1: differences, off-map test
   logic                                s1_valid_ff;
   logic                                s1_off_ff;
   logic signed [rcb_pkg::DIFF_W-1:0]   s1_dx_ff, s1_dz_ff;
   logic signed [rcb_pkg::HGT_W-1:0]    s1_h_ff;
   logic signed [rcb_pkg::DIFF_W-1:0]   s1_dx_in, s1_dz_in;
   logic                                s1_off_in;

   always_comb begin
      s1_dx_in  = $signed({1'b0, req_data.pixel_x}) - $signed({1'b0, center_x_ff});
      s1_dz_in  = $signed({1'b0, req_data.pixel_z}) - $signed({1'b0, center_z_ff});
      s1_off_in = (int'(req_data.pixel_x) >= MAP_SIDE) ||
                  (int'(req_data.pixel_z) >= MAP_SIDE);
   end

   // stage 2: squares
   logic                              s2_valid_ff;
   logic                              s2_off_ff;
   logic [rcb_pkg::SQ_W-1:0]          s2_sqx_ff, s2_sqz_ff, s2_r2_ff;
   logic signed [rcb_pkg::HGT_W-1:0]  s2_h_ff;
   logic signed [2*rcb_pkg::DIFF_W-1:0] s2_px_in, s2_pz_in;

   always_comb begin
      s2_px_in = s1_dx_ff * s1_dx_ff;
      s2_pz_in = s1_dz_ff * s1_dz_ff;
   end

   // stage 3 is entry 0 of the root pipe: sum and inside test
   logic                             sq_valid_ff [SQ_N+1];
   rcb_pkg::carry_type               sq_carry_ff [SQ_N+1];
   logic [rcb_pkg::RADICAND_W-1:0]   sq_rad_ff   [SQ_N+1];
   logic [rcb_pkg::REM_W-1:0]        sq_rem_ff   [SQ_N+1];
   logic [rcb_pkg::ROOT_W-1:0]       sq_root_ff  [SQ_N+1];
   logic [rcb_pkg::RADICAND_W-1:0]   sq_rad_in   [SQ_N+1];
   logic [rcb_pkg::REM_W-1:0]        sq_rem_in   [SQ_N+1];
   logic [rcb_pkg::ROOT_W-1:0]       sq_root_in  [SQ_N+1];
   logic [rcb_pkg::D2_W-1:0]         d2_in;
   logic                             inside_in;

   always_comb begin
      logic [rcb_pkg::REM_W-1:0] cur;
      logic [rcb_pkg::REM_W-1:0] trial;
      d2_in = rcb_pkg::D2_W'(s2_sqx_ff) + rcb_pkg::D2_W'(s2_sqz_ff);
      inside_in = (radius_ff != '0) && !s2_off_ff &&
                  (d2_in <= rcb_pkg::D2_W'(s2_r2_ff));
      sq_rad_in[0]  = {d2_in, {(2*rcb_pkg::FRAC_W){1'b0}}};
      sq_rem_in[0]  = '0;
      sq_root_in[0] = '0;
      // one root bit per stage
      for (int k = 1; k <= SQ_N; k++) begin
         cur   = {sq_rem_ff[k-1][rcb_pkg::REM_W-3:0],
                  sq_rad_ff[k-1][rcb_pkg::RADICAND_W-1 -: 2]};
         trial = rcb_pkg::REM_W'({sq_root_ff[k-1], 2'b01});
         sq_rad_in[k] = sq_rad_ff[k-1] << 2;
         if (cur >= trial) begin
            sq_rem_in[k]  = cur - trial;
            sq_root_in[k] = {sq_root_ff[k-1][rcb_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            sq_rem_in[k]  = cur;
            sq_root_in[k] = {sq_root_ff[k-1][rcb_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   // divider: entry 0 is the numerator prep stage
   logic                        dv_valid_ff [IDX_W+1];
   rcb_pkg::carry_type          dv_carry_ff [IDX_W+1];
   logic [NUM_W-1:0]            dv_num_ff   [IDX_W+1];
   logic [rcb_pkg::DIVS_W-1:0]  dv_divs_ff  [IDX_W+1];
   logic [IDX_W-1:0]            dv_quo_ff   [IDX_W+1];
   logic [NUM_W-1:0]            dv_num_in   [IDX_W+1];
   logic [IDX_W-1:0]            dv_quo_in   [IDX_W+1];

   always_comb begin
      // (2*dist*depth + 256*r) over 512*r rounds to the nearest step
      dv_num_in[0] = NUM_W'({sq_root_ff[SQ_N], 1'b0}) * NUM_W'(COS_TABLE_DEPTH)
                     + NUM_W'({radius_ff, 8'b0});
      dv_quo_in[0] = '0;
      for (int k = 1; k <= IDX_W; k++) begin
         if ((dv_num_ff[k-1] >> (IDX_W - k)) >= NUM_W'(dv_divs_ff[k-1])) begin
            dv_num_in[k] = dv_num_ff[k-1] - (NUM_W'(dv_divs_ff[k-1]) << (IDX_W - k));
            dv_quo_in[k] = {dv_quo_ff[k-1][IDX_W-2:0], 1'b1};
         end else begin
            dv_num_in[k] = dv_num_ff[k-1];
            dv_quo_in[k] = {dv_quo_ff[k-1][IDX_W-2:0], 1'b0};
         end
      end
   end

   // table lookup
   logic                        lk_valid_ff;
   rcb_pkg::carry_type          lk_carry_ff;
   logic [rcb_pkg::WT_W-1:0]    lk_w_ff;
   logic [IDX_W-1:0]            lk_idx_in;

   always_comb begin
      if (dv_quo_ff[IDX_W] > IDX_W'(COS_TABLE_DEPTH)) begin
         lk_idx_in = IDX_W'(COS_TABLE_DEPTH);
      end else begin
         lk_idx_in = dv_quo_ff[IDX_W];
      end
   end

   // multiply
   logic                               mul_valid_ff;
   rcb_pkg::carry_type                 mul_carry_ff;
   logic signed [rcb_pkg::PROD_W-1:0]  mul_prod_ff;
   logic signed [rcb_pkg::PROD_W-1:0]  mul_prod_in;

   assign mul_prod_in = bump_height_ff * $signed({1'b0, lk_w_ff});

   // round, add, saturate
   rcb_pkg::rsp_type                   rsp_in;
   logic signed [rcb_pkg::PROD_W:0]    rnd;
   logic signed [rcb_pkg::PROD_W-16:0] disp;
   logic signed [rcb_pkg::PROD_W-14:0] sum;

   always_comb begin
      rnd  = {mul_prod_ff[rcb_pkg::PROD_W-1], mul_prod_ff} + (rcb_pkg::PROD_W+1)'(32768);
      disp = rnd[rcb_pkg::PROD_W:16];
      // both terms sign-extended to the full sum width
      sum  = {{5{mul_carry_ff.height[rcb_pkg::HGT_W-1]}}, mul_carry_ff.height}
             + {{2{disp[rcb_pkg::PROD_W-16]}}, disp};
      rsp_in.inside_circle = mul_carry_ff.in_circle;
      rsp_in.saturated     = 1'b0;
      rsp_in.height_out    = mul_carry_ff.height;
      if (mul_carry_ff.in_circle) begin
         if (sum[rcb_pkg::PROD_W-14:rcb_pkg::HGT_W-1] == '0 ||
             sum[rcb_pkg::PROD_W-14:rcb_pkg::HGT_W-1] == '1) begin
            rsp_in.height_out = sum[rcb_pkg::HGT_W-1:0];
         end else begin
            rsp_in.saturated  = 1'b1;
            rsp_in.height_out = sum[rcb_pkg::PROD_W-14] ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         for (int k = 0; k <= SQ_N; k++) sq_valid_ff[k] <= 1'b0;
         for (int k = 0; k <= IDX_W; k++) dv_valid_ff[k] <= 1'b0;
         lk_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff    <= req_valid;
         s2_valid_ff    <= s1_valid_ff;
         sq_valid_ff[0] <= s2_valid_ff;
         for (int k = 1; k <= SQ_N; k++) sq_valid_ff[k] <= sq_valid_ff[k-1];
         dv_valid_ff[0] <= sq_valid_ff[SQ_N];
         for (int k = 1; k <= IDX_W; k++) dv_valid_ff[k] <= dv_valid_ff[k-1];
         lk_valid_ff    <= dv_valid_ff[IDX_W];
         mul_valid_ff   <= lk_valid_ff;
         rsp_valid_ff   <= mul_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_dx_ff  <= s1_dx_in;
         s1_dz_ff  <= s1_dz_in;
         s1_off_ff <= s1_off_in;
         s1_h_ff   <= req_data.height_in;

         s2_sqx_ff <= s2_px_in[rcb_pkg::SQ_W-1:0];
         s2_sqz_ff <= s2_pz_in[rcb_pkg::SQ_W-1:0];
         s2_r2_ff  <= radius_ff * radius_ff;
         s2_off_ff <= s1_off_ff;
         s2_h_ff   <= s1_h_ff;

         sq_carry_ff[0] <= '{height: s2_h_ff, in_circle: inside_in};
         for (int k = 1; k <= SQ_N; k++) sq_carry_ff[k] <= sq_carry_ff[k-1];
         for (int k = 0; k <= SQ_N; k++) begin
            sq_rad_ff[k]  <= sq_rad_in[k];
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
         end

         dv_carry_ff[0] <= sq_carry_ff[SQ_N];
         dv_divs_ff[0]  <= {radius_ff, 9'b0};
         for (int k = 1; k <= IDX_W; k++) begin
            dv_carry_ff[k] <= dv_carry_ff[k-1];
            dv_divs_ff[k]  <= dv_divs_ff[k-1];
         end
         for (int k = 0; k <= IDX_W; k++) begin
            dv_num_ff[k] <= dv_num_in[k];
            dv_quo_ff[k] <= dv_quo_in[k];
         end

         lk_carry_ff  <= dv_carry_ff[IDX_W];
         lk_w_ff      <= WTAB[lk_idx_in];
         mul_carry_ff <= lk_carry_ff;
         mul_prod_ff  <= mul_prod_in;
         rsp_ff       <= rsp_in;
      end
   end

   // checks
   `RCB_ASSERT_SAME(a_outside_clean, clock, reset,
      rsp_valid_ff && !rsp_ff.inside_circle, !rsp_ff.saturated)
   `RCB_ASSERT_SAME(a_sat_rails, clock, reset, rsp_valid_ff && rsp_ff.saturated,
      rsp_ff.height_out == 32'sh7fff_ffff || rsp_ff.height_out == 32'sh8000_0000)
   `RCB_ASSERT_SAME(a_root_in_radius, clock, reset,
      sq_valid_ff[SQ_N] && sq_carry_ff[SQ_N].in_circle,
      sq_root_ff[SQ_N] <= rcb_pkg::ROOT_W'({radius_ff, 8'b0}))
   `RCB_ASSERT_SAME(a_index_in_table, clock, reset,
      dv_valid_ff[IDX_W] && dv_carry_ff[IDX_W].in_circle,
      dv_quo_ff[IDX_W] <= IDX_W'(COS_TABLE_DEPTH))
   `RCB_ASSERT_NEXT(a_out_loads, clock, reset, mul_valid_ff && adv, rsp_valid_ff)

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;

   localparam int DEPTH   = 256;
   localparam int LATENCY = 35;
   localparam int SETTLE  = LATENCY + 8;

   // Golden bump model plus the queue of heights still owed by the block.
   class bump_scoreboard;
      rcb_pkg::rsp_type pending[$];
      int unsigned  weight[DEPTH+1];
      int unsigned  cx, cz, radius;
      longint       amp;
      int           errors;

      function new();
         cx = 0; cz = 0; radius = 1; amp = 0; errors = 0;
         for (int k = 0; k <= DEPTH; k++) begin
            longint c, w;
            if (2 * k <= DEPTH) c = cos_fixed(rcb_pkg::PI_Q30 * k / DEPTH);
            else c = -cos_fixed(rcb_pkg::PI_Q30 * (DEPTH - k) / DEPTH);
            w = (longint'(rcb_pkg::ONE_Q30) + c) / 2;
            if (w < 0) w = 0;
            weight[k] = int'((longint'(w) + (64'd1 << 13)) >> 14);
         end
      endfunction

      // Taylor series in Q30, truncating each step
      function longint cos_fixed(longint unsigned theta);
         longint unsigned sq, term;
         longint acc;
         sq = (theta * theta) >> 30;
         term = 64'd1 << 30;
         acc = 64'sd1 << 30;
         for (int n = 1; n <= 12; n++) begin
            term = ((term * sq) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
         end
         return acc;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function void write_reg(logic [rcb_pkg::CSR_W-1:0] idx,
                              logic [rcb_pkg::HGT_W-1:0] val);
         case (idx)
            rcb_pkg::CSR_CENTER_X: cx = val[9:0];
            rcb_pkg::CSR_CENTER_Z: cz = val[9:0];
            rcb_pkg::CSR_RADIUS:   radius = val[9:0];
            rcb_pkg::CSR_HEIGHT:   amp = longint'($signed(val));
            default: ;
         endcase
      endfunction

      function void note_pixel(rcb_pkg::req_type px);
         rcb_pkg::rsp_type e;
         longint        dx, dz, h, sum, prod, disp;
         longint unsigned d2, dq8, idx;
         dx = longint'(px.pixel_x) - longint'(cx);
         dz = longint'(px.pixel_z) - longint'(cz);
         d2 = dx * dx + dz * dz;
         h = longint'(px.height_in);
         sum = h;
         e.saturated = 1'b0;
         e.inside_circle = (radius != 0) && (d2 <= radius * radius);
         if (e.inside_circle) begin
            dq8 = int_sqrt(d2 << 16);
            idx = (2 * dq8 * DEPTH + 256 * radius) / (512 * radius);
            if (idx > DEPTH) idx = DEPTH;
            prod = amp * longint'(weight[idx]);
            disp = (prod + 32768) >>> 16;
            sum = h + disp;
            if (sum > 64'sd2147483647) begin
               sum = 64'sd2147483647; e.saturated = 1'b1;
            end else if (sum < -64'sd2147483648) begin
               sum = -64'sd2147483648; e.saturated = 1'b1;
            end
         end
         e.height_out = sum[31:0];
         pending.push_back(e);
      endfunction

      function void check_result(rcb_pkg::rsp_type got);
         rcb_pkg::rsp_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
         end
         e = pending.pop_front();
         if (got.height_out !== e.height_out || got.inside_circle !== e.inside_circle ||
             got.saturated !== e.saturated) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp h=%0d in=%b sat=%b got h=%0d in=%b sat=%b",
                        e.height_out, e.inside_circle, e.saturated,
                        got.height_out, got.inside_circle, got.saturated);
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   rcb_pkg::req_type          req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rcb_pkg::rsp_type          rsp_data;
   logic                      csr_we;
   logic [rcb_pkg::CSR_W-1:0] csr_index;
   logic [rcb_pkg::HGT_W-1:0] csr_wdata;

   bump_scoreboard sb = new();
   int  rsp_count = 0;
   bit  quiet_tx, quiet_rx;   // stretches with no idle cycles

   raised_cosine_bump_adder u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Watch both handshakes at the edge; values read here are pre-update.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_pixel(req_data);
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_data);
         rsp_count++;
      end
   end

   // Result side: random stall per item, one long hold to back up the pipe.
   initial begin : receiver
      int n;
      bit held;
      held = 0;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         if (!held && rsp_count >= 150) begin
            held = 1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end
         n = quiet_rx ? 0 : $urandom_range(0, 7);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_pixel(logic [9:0] x, logic [9:0] z, logic [31:0] h);
      int gap;
      gap = quiet_tx ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{pixel_x: x, pixel_z: z, height_in: h};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Let the pipe drain before touching the registers.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // csr_we is dropped after each write, keeping back-to-back writes apart.
   task automatic write_csr(logic [rcb_pkg::CSR_W-1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic set_bump(int x, int z, int r, logic [31:0] a);
      drain();
      write_csr(rcb_pkg::CSR_CENTER_X, x);
      write_csr(rcb_pkg::CSR_CENTER_Z, z);
      write_csr(rcb_pkg::CSR_RADIUS, r);
      write_csr(rcb_pkg::CSR_HEIGHT, a);
   endtask

   function automatic logic [31:0] rand_height();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Coordinate near the centre, clipped to the map.
   function automatic logic [9:0] near(int c, int r);
      int v;
      v = c + $urandom_range(0, 2 * r + 2) - r - 1;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return 10'(v);
   endfunction

   initial begin : stimulus
      int r;
      logic [31:0] a;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet_tx = 0;
      quiet_rx = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: radius 1 at the origin, zero amplitude still flags inside.
      send_pixel(0, 0, 32'h1234_5678);
      send_pixel(1, 0, 32'h8000_0000);
      send_pixel(1, 1, 32'h7fff_ffff);
      send_pixel(1023, 1023, 32'h0);

      // Full-height bump: saturation on top, edge of circle, far corner.
      set_bump(512, 512, 1023, 32'h7fff_ffff);
      send_pixel(512, 512, 32'h7fff_ffff);
      send_pixel(512, 512, 32'h0);
      send_pixel(0, 512, 32'h1);
      send_pixel(512, 1023, 32'hffff_0000);
      send_pixel(0, 0, 32'h0);
      set_bump(1023, 0, 1023, 32'h8000_0000);
      send_pixel(1023, 0, 32'h8000_0000);
      send_pixel(0, 0, 32'h0);
      send_pixel(1023, 1023, 32'h7fff_ffff);
      send_pixel(500, 500, 32'h0001_0000);

      // Zero radius, and unknown indexes that must change nothing.
      set_bump(5, 5, 0, 32'h0100_0000);
      write_csr(3'd4, 32'hffff_ffff);
      write_csr(3'd7, 32'hffff_ffff);
      send_pixel(5, 5, 32'h0);
      send_pixel(6, 5, 32'h0);
      set_bump(0, 1023, 1, 32'h0001_0000);
      write_csr(3'd5, 32'h0);
      write_csr(3'd6, 32'h3ff);
      send_pixel(0, 1023, 32'h0);
      send_pixel(1, 1023, 32'hffff_ffff);
      send_pixel(1, 1022, 32'h0);

      // Random phases, mostly pixels in and around the circle.
      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: r = 1023;
            1: r = 1;
            2: r = 0;
            default: r = (ph % 2) ? $urandom_range(1, 40) : $urandom_range(1, 1023);
         endcase
         a = (ph == 3) ? 32'h8000_0000 : (ph == 4) ? 32'h7fff_ffff : $urandom;
         set_bump($urandom_range(0, 1023), $urandom_range(0, 1023), r, a);
         for (int i = 0; i < 92; i++) begin
            if (i % 30 == 0) begin
               quiet_tx = ($urandom_range(0, 3) == 0);
               quiet_rx = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 9) < 7)
               send_pixel(near(sb.cx, r), near(sb.cz, r), rand_height());
            else
               send_pixel(10'($urandom), 10'($urandom), rand_height());
         end
      end

      req_valid <= 1'b0;
      quiet_rx = 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS raised_cosine_bump_adder");
      end else begin
         $display("FAIL raised_cosine_bump_adder");
      end
      $finish;
   end

   // Allow many times the length of the slowest run before failing.
   initial begin : watchdog
      #5ms;
      $display("FAIL raised_cosine_bump_adder");
      $finish;
   end
endmodule
`default_nettype wire
